FILE: hw/rtl/c8x_pkg.sv
// Shared types and constants for the CHIP-8 instruction execute unit.
// No dependencies.
package c8x_pkg;

    localparam int MemBytes    = 4096;
    localparam int StackDepth  = 16;
    localparam int AddrW       = 12;

    localparam logic [1:0] ST_EXEC   = 2'd0;
    localparam logic [1:0] ST_UNIMP  = 2'd1;
    localparam logic [1:0] ST_LOADED = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SE   = 4'h3;
    localparam logic [3:0] OP_SNE  = 4'h4;
    localparam logic [3:0] OP_SER  = 4'h5;
    localparam logic [3:0] OP_LD   = 4'h6;
    localparam logic [3:0] OP_ADD  = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_SNER = 4'h9;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_JPV  = 4'hB;
    localparam logic [3:0] OP_RND  = 4'hC;
    localparam logic [3:0] OP_MISC = 4'hF;

    localparam logic [7:0] MISC_GETDT = 8'h07;
    localparam logic [7:0] MISC_SETDT = 8'h15;
    localparam logic [7:0] MISC_SETST = 8'h18;
    localparam logic [7:0] MISC_ADDI  = 8'h1E;
    localparam logic [7:0] MISC_BCD   = 8'h33;
    localparam logic [7:0] MISC_STORE = 8'h55;
    localparam logic [7:0] MISC_FILL  = 8'h65;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the input item
        logic execute;   // apply the opcode's state update
        logic mem_wr;    // write the memory at the sequence address
        logic mem_rd;    // issue a memory read for the sequence address
        logic reg_ld;    // write returned read data into V[count-1]
        logic step;      // advance the sequence counter
        logic finish;    // close a memory-sequence opcode (I update for store)
    } c8x_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_load;
        logic is_bcd;
        logic is_store;
        logic is_fill;
        logic last;      // sequence counter at its final element
    } c8x_stat_t;

endpackage

FILE: hw/rtl/c8x_datapath.sv
// Datapath: registers V0..VF, I, PC, timers, return stack and byte memory.
// Depends on c8x_pkg.
module c8x_datapath #(
    parameter int STACK_DEPTH = c8x_pkg::StackDepth
) (
    input  logic               clk,
    input  logic               rst_n,
    input  c8x_pkg::c8x_cmd_t  cmd,
    output c8x_pkg::c8x_stat_t stat,
    input  logic [44:0]        in_item,
    output logic [53:0]        out_item
);
    import c8x_pkg::*;

    localparam int SpW = $clog2(STACK_DEPTH + 1);
    localparam int SiW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [7:0]       v_reg [16];
    logic [11:0]      pc_reg;
    logic [15:0]      i_reg;
    logic [SpW-1:0]   sp_reg;
    logic [7:0]       dt_reg, st_reg;
    logic [1:0]       status_reg;
    logic [11:0]      rstack [STACK_DEPTH];
    logic [7:0]       mem [MemBytes];
    logic [7:0]       rd_data_reg;

    logic [44:0]      item_reg;
    logic [3:0]       cnt_reg;

    logic        cmd_ld;
    logic [15:0] op;
    logic [3:0]  x, y, hi;
    logic [7:0]  nn, vx, vy, v0;
    logic [11:0] nnn, pc2, pc4;

    assign cmd_ld = item_reg[0];
    assign op     = item_reg[16:1];
    assign hi     = op[15:12];
    assign x      = op[11:8];
    assign y      = op[7:4];
    assign nn     = op[7:0];
    assign nnn    = op[11:0];
    assign vx     = v_reg[x];
    assign vy     = v_reg[y];
    assign v0     = v_reg[0];
    assign pc2    = pc_reg + 12'd2;
    assign pc4    = pc_reg + 12'd4;

    // BCD digits of VX
    logic [7:0] hund, tens, ones, bcd_byte;
    always_comb
    begin
        hund = 8'd0;
        if (vx >= 8'd200) hund = 8'd2;
        else if (vx >= 8'd100) hund = 8'd1;
        ones = vx - 8'(hund * 8'd100);
        tens = 8'(({8'd0, ones} * 16'd205) >> 11);
        ones = ones - 8'(tens * 8'd10);
        case (cnt_reg[1:0])
            2'd0:    bcd_byte = hund;
            2'd1:    bcd_byte = tens;
            default: bcd_byte = ones;
        endcase
    end

    logic [11:0] seq_addr;
    logic [15:0] seq_sum;
    assign seq_sum  = i_reg + {12'd0, cnt_reg};
    assign seq_addr = cmd_ld ? item_reg[36:25] : seq_sum[11:0];

    assign stat.is_load  = cmd_ld;
    assign stat.is_bcd   = !cmd_ld && hi == OP_MISC && nn == MISC_BCD;
    assign stat.is_store = !cmd_ld && hi == OP_MISC && nn == MISC_STORE;
    assign stat.is_fill  = !cmd_ld && hi == OP_MISC && nn == MISC_FILL;
    assign stat.last     = stat.is_bcd ? (cnt_reg == 4'd2) : (cnt_reg == x);

    // Memory port: one write or one read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            if (cmd_ld) mem[seq_addr] <= item_reg[44:37];
            else if (stat.is_bcd) mem[seq_addr] <= bcd_byte;
            else mem[seq_addr] <= v_reg[cnt_reg];
        end
        if (cmd.mem_rd)
            rd_data_reg <= mem[seq_addr];
    end

    // Return stack
    always_ff @(posedge clk)
    begin
        if (cmd.execute && hi == OP_CALL && sp_reg < SpW'(STACK_DEPTH))
            rstack[sp_reg[SiW-1:0]] <= pc2;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= in_item;
    end

    // Architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        logic [8:0] sum9;
        logic [12:0] bsum;
        if (!rst_n)
        begin
            for (int k = 0; k < 16; k++) v_reg[k] <= 8'd0;
            pc_reg     <= 12'h200;
            i_reg      <= 16'd0;
            sp_reg     <= '0;
            dt_reg     <= 8'd0;
            st_reg     <= 8'd0;
            status_reg <= ST_EXEC;
            cnt_reg    <= 4'd0;
        end
        else
        begin
            if (cmd.capture) cnt_reg <= 4'd0;
            if (cmd.step) cnt_reg <= cnt_reg + 4'd1;
            if (cmd.reg_ld) v_reg[cnt_reg - 4'd1] <= rd_data_reg;
            if (cmd.finish)
            begin
                if (stat.is_store) i_reg <= i_reg + {12'd0, x} + 16'd1;
            end
            if (cmd.execute)
            begin
                status_reg <= ST_EXEC;
                pc_reg <= pc2;
                if (cmd_ld)
                begin
                    pc_reg <= pc_reg;
                    status_reg <= ST_LOADED;
                end
                else
                begin
                    case (hi)
                        OP_JP: pc_reg <= nnn;
                        OP_CALL:
                            if (sp_reg >= SpW'(STACK_DEPTH)) status_reg <= ST_FULL;
                            else
                            begin
                                sp_reg <= sp_reg + SpW'(1);
                                pc_reg <= nnn;
                            end
                        OP_SE:   if (vx == nn) pc_reg <= pc4;
                        OP_SNE:  if (vx != nn) pc_reg <= pc4;
                        OP_SER:  if (vx == vy) pc_reg <= pc4;
                        OP_SNER: if (vx != vy) pc_reg <= pc4;
                        OP_JPV:
                        begin
                            bsum = {1'b0, nnn} + {5'd0, v0};
                            v_reg[15] <= {7'd0, bsum > 13'd255};
                            pc_reg <= bsum[11:0];
                        end
                        OP_LD:  v_reg[x] <= nn;
                        OP_ADD: v_reg[x] <= vx + nn;
                        OP_LDI: i_reg <= {4'd0, nnn};
                        OP_RND: v_reg[x] <= item_reg[24:17] & nn;
                        OP_ALU:
                        begin
                            case (op[3:0])
                                4'h0: v_reg[x] <= vy;
                                4'h1: v_reg[x] <= vx | vy;
                                4'h2: v_reg[x] <= vx & vy;
                                4'h3: v_reg[x] <= vx ^ vy;
                                4'h4:
                                begin
                                    sum9 = {1'b0, vx} + {1'b0, vy};
                                    v_reg[15] <= {7'd0, sum9[8]};
                                    v_reg[x] <= sum9[7:0];
                                end
                                4'h5:
                                begin
                                    v_reg[15] <= {7'd0, vx >= vy};
                                    v_reg[x] <= vx - vy;
                                end
                                4'h6:
                                begin
                                    v_reg[15] <= {7'd0, vx[0]};
                                    v_reg[x] <= {1'b0, vx[7:1]};
                                end
                                4'h7:
                                begin
                                    v_reg[15] <= {7'd0, vy >= vx};
                                    v_reg[x] <= vy - vx;
                                end
                                4'hE:
                                begin
                                    v_reg[15] <= {7'd0, vx[7]};
                                    v_reg[x] <= {vx[6:0], 1'b0};
                                end
                                default: status_reg <= ST_UNIMP;
                            endcase
                        end
                        OP_MISC:
                        begin
                            case (nn)
                                MISC_GETDT: v_reg[x] <= dt_reg;
                                MISC_SETDT: dt_reg <= vx;
                                MISC_SETST: st_reg <= vx;
                                MISC_ADDI:  i_reg <= i_reg + {8'd0, vx};
                                MISC_BCD, MISC_STORE, MISC_FILL: ;
                                default: status_reg <= ST_UNIMP;
                            endcase
                        end
                        default: status_reg <= ST_UNIMP;
                    endcase
                end
            end
        end
    end

    // fields low to high: next_pc, index_value, flag_value, delay, sound, status
    assign out_item = {status_reg, st_reg, dt_reg, v_reg[15], i_reg, pc_reg};

endmodule

FILE: hw/rtl/c8x_control.sv
// Controller state machine sequencing plain and memory opcodes.
// Depends on c8x_pkg.
module c8x_control (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output c8x_pkg::c8x_cmd_t  cmd,
    input  c8x_pkg::c8x_stat_t stat
);
    import c8x_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DEC   = 5'b00010,
        S_WSEQ  = 5'b00100,
        S_RSEQ  = 5'b01000,
        S_RLAST = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   rd_pend_reg;

    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
                if (s_valid && s_ready)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DEC;
                end
            S_DEC:
                if (stat.is_load)
                begin
                    cmd.mem_wr = 1'b1;
                    cmd.execute = 1'b1;
                    m_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.is_bcd || stat.is_store)
                    state_next = S_WSEQ;
                else if (stat.is_fill)
                    state_next = S_RSEQ;
                else
                begin
                    cmd.execute = 1'b1;
                    m_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            S_WSEQ:
            begin
                cmd.mem_wr = 1'b1;
                cmd.step = 1'b1;
                if (stat.last)
                begin
                    cmd.execute = 1'b1;
                    cmd.finish = 1'b1;
                    m_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RSEQ:
            begin
                cmd.mem_rd = 1'b1;
                cmd.reg_ld = rd_pend_reg;
                cmd.step = 1'b1;
                if (state_reg == S_RSEQ && stat.last) state_next = S_RLAST;
            end
            S_RLAST:
            begin
                cmd.reg_ld = 1'b1;
                cmd.execute = 1'b1;
                m_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // load previous read while issuing the next
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            rd_pend_reg <= cmd.mem_rd;
        end
    end

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_ready)
        else $error("input taken while busy");
    a_result_after_rlast: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RLAST) |=> m_valid)
        else $error("fill finished without result");
    a_rlast_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RLAST) |-> rd_pend_reg)
        else $error("fill end without pending read");
`endif

endmodule

FILE: hw/rtl/chip8_instruction_execute_unit.sv
// Top level of the CHIP-8 instruction execute unit.
// Depends on c8x_pkg, c8x_control and c8x_datapath.
//
// Usage: one input transfer on s_axis carries either an opcode to execute
// (command 0) or one memory byte to write (command 1). Each input transfer
// yields exactly one result transfer on m_axis with PC, I, VF, the timers
// and a status code.
// Plain opcodes and memory byte writes complete in the decode state; FX33
// and FX55 write their bytes and FX65 reads its bytes through the single
// memory port that moves one byte per cycle. One item is in work at a time;
// the next is accepted in the cycle its result is taken or once the result
// register is empty.
// Reset puts V0..VF, I, timers and stack depth at zero and PC at 0x200; the
// memory and return stack hold no defined contents until written. While a
// result is valid and m_axis_tready is low it holds in its register and no
// new input is accepted.
module chip8_instruction_execute_unit #(
    parameter int STACK_DEPTH = c8x_pkg::StackDepth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[0], instruction_word[16:1], random_byte[24:17],
    // load_address[36:25], load_data[44:37], zero fill to 48 bits
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // next_pc[11:0], index_value[27:12], flag_value[35:28],
    // delay_value[43:36], sound_value[51:44], status[53:52], zero to 56
    output logic [55:0] m_axis_tdata
);
    import c8x_pkg::*;

    c8x_cmd_t    cmd;
    c8x_stat_t   stat;
    logic [53:0] out_item;
    logic [44:0] in_item;

    // pack item: command, opcode, random, address, data
    assign in_item = s_axis_tdata[44:0];

    c8x_control u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .cmd     (cmd),
        .stat    (stat)
    );

    c8x_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_item  (in_item),
        .out_item (out_item)
    );

    assign m_axis_tdata = {2'd0, out_item};

endmodule

FILE: sim/tb_chip8_instruction_execute_unit.sv
// Self-checking testbench for the CHIP-8 instruction execute unit.
// Runs directed tests and random opcode streams against an in-bench predictor.
// Depends on c8x_pkg and chip8_instruction_execute_unit.
module tb_chip8_instruction_execute_unit;
    import c8x_pkg::*;

    typedef struct packed {
        logic [11:0] pc;
        logic [15:0] idx;
        logic [7:0]  vf;
        logic [7:0]  dt;
        logic [7:0]  st;
        logic [1:0]  status;
    } cpu_view_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;

    // Predictor state
    logic [7:0]  vreg [16];
    logic [11:0] pc_q;
    logic [15:0] idx_q;
    int          depth_q;
    logic [7:0]  dt_q;
    logic [7:0]  st_q;
    logic [7:0]  mem_image [MemBytes];
    bit          mem_written [MemBytes];

    cpu_view_t   expected_views [$];
    int          errors;
    int          no_idle;
    int          hold_off;
    int          idle_cycles;

    chip8_instruction_execute_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle != 0 || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] opcode(logic [3:0] grp, logic [3:0] x, logic [7:0] low);
        return {grp, x, low};
    endfunction

    // Compute the architectural view after one item and update state
    function automatic cpu_view_t execute_item(bit cmd, logic [15:0] op, logic [7:0] rnd,
                                               logic [11:0] la, logic [7:0] ld);
        cpu_view_t   v;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [7:0]  nn;
        logic [11:0] nnn;
        logic [11:0] pc2;
        logic [7:0]  vx;
        logic [7:0]  vy;
        logic [8:0]  wide;
        logic [7:0]  res;
        logic [7:0]  flag;
        bit          has_flag;
        logic [1:0]  status;
        x = op[11:8];
        y = op[7:4];
        nn = op[7:0];
        nnn = op[11:0];
        pc2 = pc_q + 12'd2;
        vx = vreg[x];
        vy = vreg[y];
        status = ST_EXEC;
        if (cmd)
        begin
            mem_image[la] = ld;
            mem_written[la] = 1'b1;
            status = ST_LOADED;
        end
        else
        begin
            case (op[15:12])
                OP_JP: pc_q = nnn;
                OP_CALL:
                begin
                    if (depth_q >= StackDepth)
                    begin
                        pc_q = pc2;
                        status = ST_FULL;
                    end
                    else
                    begin
                        depth_q++;
                        pc_q = nnn;
                    end
                end
                OP_SE:   pc_q = pc_q + ((vx == nn) ? 12'd4 : 12'd2);
                OP_SNE:  pc_q = pc_q + ((vx != nn) ? 12'd4 : 12'd2);
                OP_SER:  pc_q = pc_q + ((vx == vy) ? 12'd4 : 12'd2);
                OP_SNER: pc_q = pc_q + ((vx != vy) ? 12'd4 : 12'd2);
                OP_JPV:
                begin
                    vreg[15] = ({5'd0, vreg[0]} + {1'b0, nnn} > 13'd255) ? 8'd1 : 8'd0;
                    pc_q = nnn + {4'd0, vreg[0]};
                end
                default:
                begin
                    case (op[15:12])
                        OP_LD:  vreg[x] = nn;
                        OP_ADD: vreg[x] = vx + nn;
                        OP_LDI: idx_q = {4'd0, nnn};
                        OP_RND: vreg[x] = rnd & nn;
                        OP_ALU:
                        begin
                            has_flag = 1'b1;
                            flag = 8'd0;
                            res = 8'd0;
                            case (op[3:0])
                                4'h0: begin res = vy; has_flag = 1'b0; end
                                4'h1: begin res = vx | vy; has_flag = 1'b0; end
                                4'h2: begin res = vx & vy; has_flag = 1'b0; end
                                4'h3: begin res = vx ^ vy; has_flag = 1'b0; end
                                4'h4:
                                begin
                                    wide = {1'b0, vx} + {1'b0, vy};
                                    res = wide[7:0];
                                    flag = {7'd0, wide[8]};
                                end
                                4'h5: begin res = vx - vy; flag = {7'd0, vx >= vy}; end
                                4'h6: begin res = vx >> 1; flag = {7'd0, vx[0]}; end
                                4'h7: begin res = vy - vx; flag = {7'd0, vy >= vx}; end
                                4'hE: begin res = vx << 1; flag = {7'd0, vx[7]}; end
                                default: begin status = ST_UNIMP; has_flag = 1'b0; end
                            endcase
                            if (status == ST_EXEC)
                            begin
                                if (has_flag)
                                    vreg[15] = flag;
                                vreg[x] = res;
                            end
                        end
                        OP_MISC:
                        begin
                            case (nn)
                                MISC_GETDT: vreg[x] = dt_q;
                                MISC_SETDT: dt_q = vx;
                                MISC_SETST: st_q = vx;
                                MISC_ADDI:  idx_q = idx_q + {8'd0, vx};
                                MISC_BCD:
                                begin
                                    mem_image[idx_q[11:0]] = vx / 100;
                                    mem_image[idx_q[11:0] + 12'd1] = (vx / 10) % 10;
                                    mem_image[idx_q[11:0] + 12'd2] = vx % 10;
                                    for (int k = 0; k < 3; k++)
                                        mem_written[idx_q[11:0] + 12'(k)] = 1'b1;
                                end
                                MISC_STORE:
                                begin
                                    for (int k = 0; k <= x; k++)
                                    begin
                                        mem_image[idx_q[11:0] + 12'(k)] = vreg[k];
                                        mem_written[idx_q[11:0] + 12'(k)] = 1'b1;
                                    end
                                    idx_q = idx_q + {12'd0, x} + 16'd1;
                                end
                                MISC_FILL:
                                begin
                                    for (int k = 0; k <= x; k++)
                                        vreg[k] = mem_image[idx_q[11:0] + 12'(k)];
                                end
                                default: status = ST_UNIMP;
                            endcase
                        end
                        default: status = ST_UNIMP;
                    endcase
                    pc_q = pc2;
                end
            endcase
        end
        v.pc = pc_q;
        v.idx = idx_q;
        v.vf = vreg[15];
        v.dt = dt_q;
        v.st = st_q;
        v.status = status;
        return v;
    endfunction

    // Offer one item, wait for its transfer, then record the expected view
    task automatic send_item(bit cmd, logic [15:0] op, logic [7:0] rnd,
                             logic [11:0] la, logic [7:0] ld);
        int g;
        g = idle_gap();
        if (g > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (g) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {3'd0, ld, la, rnd, op, cmd};
        forever
        begin
            @(posedge clk);
            if (s_axis_tready)
                break;
        end
        expected_views.push_back(execute_item(cmd, op, rnd, la, ld));
        @(negedge clk);
    endtask

    task automatic send_op(logic [15:0] op);
        send_item(1'b0, op, 8'($urandom), 12'($urandom), 8'($urandom));
    endtask

    task automatic send_write(logic [11:0] la, logic [7:0] ld);
        send_item(1'b1, 16'($urandom), 8'($urandom), la, ld);
    endtask

    // Drop valid and hold until every expected view has arrived
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (expected_views.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_memory_writes();
        send_write(12'h000, 8'hFF);
        send_write(12'hFFF, 8'h00);
        send_write(12'hABC, 8'h5A);
    endtask

    task automatic test_alu();
        send_op(opcode(OP_LD, 4'h0, 8'hFF));
        send_op(opcode(OP_LD, 4'h1, 8'h01));
        send_op(opcode(OP_ADD, 4'h1, 8'hFF));
        send_op(opcode(OP_LD, 4'h1, 8'h81));
        for (int s = 0; s < 8; s++)
            send_op(opcode(OP_ALU, 4'h2, {4'h0, 4'(s)}) | 16'h0010);
        send_op(16'h8E0E);
        send_op(16'h8F04);
        send_op(16'h8F15);
        send_op(16'h8009);
    endtask

    task automatic test_skips_and_jumps();
        send_op(opcode(OP_SE, 4'h0, 8'hFF));
        send_op(opcode(OP_SNE, 4'h0, 8'hFF));
        send_op(16'h5010);
        send_op(16'h5011);
        send_op(16'h9010);
        send_op(16'h1FFE);
        send_op(opcode(OP_SE, 4'h0, 8'hFF));
        send_op(16'hB0FF);
        send_op(16'hB000);
    endtask

    task automatic test_misc();
        send_op(16'hF015);
        send_op(16'hF118);
        send_op(16'hF307);
        send_op(16'hC0A5);
        send_op(16'hAFFE);
        send_op(16'hF033);
        send_op(16'hF255);
        send_op(16'hAFFE);
        send_op(16'hF265);
        send_op(16'hF0FF);
    endtask

    task automatic test_unimplemented();
        send_op(16'h00E0);
        send_op(16'h00EE);
        send_op(16'h0123);
        send_op(16'hD125);
        send_op(16'hE09E);
        send_op(16'hF00A);
        send_op(16'hF029);
    endtask

    task automatic test_index_wrap();
        send_op(16'hAFFF);
        send_op(16'h61FF);
        for (int k = 0; k < 260; k++)
            send_op(16'hF11E);
        send_op(16'hFF55);
    endtask

    task automatic test_stack_full();
        for (int k = 0; k <= StackDepth; k++)
            send_op(16'h2300 | 16'(k));
    endtask

    // Mostly legal opcodes with random operands; fills only read written bytes
    task automatic test_random_stream(int count);
        logic [15:0] op;
        logic [3:0]  x;
        logic [7:0]  misc_codes [7];
        int          room;
        misc_codes = '{MISC_GETDT, MISC_SETDT, MISC_SETST, MISC_ADDI,
                       MISC_BCD, MISC_STORE, MISC_FILL};
        for (int n = 0; n < count; n++)
        begin
            op = 16'($urandom);
            x = op[11:8];
            if ($urandom_range(0, 9) == 0)
            begin
                send_write(($urandom_range(0, 1) != 0) ? idx_q[11:0] + 12'($urandom_range(0, 15))
                                                      : 12'($urandom), 8'($urandom));
                continue;
            end
            if (op[15:12] == OP_ALU && $urandom_range(0, 9) != 0)
                op[3:0] = ($urandom_range(0, 8) == 8) ? 4'hE : 4'($urandom_range(0, 7));
            if (op[15:12] == OP_MISC && $urandom_range(0, 9) != 0)
                op[7:0] = misc_codes[$urandom_range(0, 6)];
            if (op[15:12] == OP_MISC && op[7:0] == MISC_FILL)
            begin
                if (!mem_written[idx_q[11:0]])
                    send_write(idx_q[11:0], 8'($urandom));
                room = 0;
                while (room < 15 && mem_written[idx_q[11:0] + 12'(room + 1)])
                    room++;
                if (x > room)
                    op[11:8] = 4'(room);
            end
            send_op(op);
        end
    endtask

    // Stall the result side for a long stretch while items are offered
    task automatic test_backpressure();
        hold_off = 300;
        test_random_stream(8);
        drain();
    endtask

    // Drive result-side ready with random stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= (idle_gap() == 0);
    end

    // Check each result transfer against the oldest expected view
    always @(posedge clk)
    begin
        cpu_view_t e;
        cpu_view_t a;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            a.pc = m_axis_tdata[11:0];
            a.idx = m_axis_tdata[27:12];
            a.vf = m_axis_tdata[35:28];
            a.dt = m_axis_tdata[43:36];
            a.st = m_axis_tdata[51:44];
            a.status = m_axis_tdata[53:52];
            if (expected_views.size() == 0)
            begin
                $error("result transfer with nothing expected");
                errors++;
            end
            else
            begin
                e = expected_views.pop_front();
                if (e.pc != a.pc)
                begin
                    $error("next_pc expected %h actual %h", e.pc, a.pc);
                    errors++;
                end
                if (e.idx != a.idx)
                begin
                    $error("index_value expected %h actual %h", e.idx, a.idx);
                    errors++;
                end
                if (e.vf != a.vf)
                begin
                    $error("flag_value expected %h actual %h", e.vf, a.vf);
                    errors++;
                end
                if (e.dt != a.dt)
                begin
                    $error("delay_value expected %h actual %h", e.dt, a.dt);
                    errors++;
                end
                if (e.st != a.st)
                begin
                    $error("sound_value expected %h actual %h", e.st, a.st);
                    errors++;
                end
                if (e.status != a.status)
                begin
                    $error("status expected %0d actual %0d", e.status, a.status);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing transfers for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= 4000)
        begin
            $display("** chip8_instruction_execute_unit: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        errors = 0;
        no_idle = 0;
        hold_off = 0;
        idle_cycles = 0;
        for (int k = 0; k < 16; k++)
            vreg[k] = 8'd0;
        pc_q = 12'h200;
        idx_q = 16'd0;
        depth_q = 0;
        dt_q = 8'd0;
        st_q = 8'd0;
        for (int k = 0; k < MemBytes; k++)
        begin
            mem_image[k] = 8'd0;
            mem_written[k] = 1'b0;
        end
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_memory_writes();
        test_alu();
        test_skips_and_jumps();
        test_misc();
        test_unimplemented();
        test_stack_full();
        test_index_wrap();
        drain();
        test_random_stream(200);
        test_backpressure();
        no_idle = 1;
        test_random_stream(150);
        no_idle = 0;
        test_random_stream(360);
        drain();

        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("** chip8_instruction_execute_unit: PASSED **");
        else
            $display("** chip8_instruction_execute_unit: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/c8x_pkg.sv
hw/rtl/c8x_datapath.sv
hw/rtl/c8x_control.sv
hw/rtl/chip8_instruction_execute_unit.sv
sim/tb_chip8_instruction_execute_unit.sv
